// File: hdl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants
// Table sizing, command codes, fit policy codes and the queued operation word.
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int MAX_BLOCKS = 128;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int SIZE_W     = 16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// input command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_REQ   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// fit policy codes (any other code behaves as first fit)
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_REQ,
		OP_CLEAR
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [SIZE_W-1:0]   size;
		logic                last;
	} op_t;

	typedef struct packed {
		logic vld;
		op_t  op;
	} op_word_t;

endpackage

// File: hdl/fpba_if.sv
// ----------------------------------------------------------------------------
// fpba_if: handshake channels of the allocator
// Item channel carries commands in, result channel carries grant words out.
// ----------------------------------------------------------------------------
interface fpba_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] block_size;
	logic [15:0] request_size;
	logic        last_request;

	modport source (output valid, cmd, block_size, request_size, last_request,
		input ready);
	modport sink (input valid, cmd, block_size, request_size, last_request,
		output ready);
endinterface

interface fpba_result_if;
	logic        valid;
	logic        ready;
	logic        granted;
	logic [15:0] granted_size;
	logic [15:0] wastage;

	modport source (output valid, granted, granted_size, wastage, input ready);
	modport sink (input valid, granted, granted_size, wastage, output ready);
endinterface

// File: hdl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator: first, best and worst fit block allocator
// Loads free block sizes into a table and grants requests by the fit policy.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | carries
//  item     | in        | valid/ready   | cmd, block_size, request_size, last_request
//  result   | out       | valid/ready   | granted, granted_size, wastage
//  cfg      | in        | cfg_we only   | fit_policy in cfg_wdata
//
//  Load and clear words are handled by the table unit while it is idle.
//  A request scans the block table through its single read port, one entry a
//  cycle; on an empty table the scan is skipped.
//  Decode and table unit are parted by a four word queue; the result register
//  lets the table unit carry on with loads and clears while a grant waits.
//  arst_n empties the table, the used marks, the queue and sets first fit.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator (
	input  logic          clk,
	input  logic          arst_n,
	fpba_item_if.sink     item,
	fpba_result_if.source result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata
);

	fpba_pkg::op_word_t q_push;
	fpba_pkg::op_word_t q_pop;
	logic               q_push_rdy;
	logic               q_pop_rdy;

	fpba_front u_front (
		.item     (item),
		.push     (q_push),
		.push_rdy (q_push_rdy)
	);

	fpba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rdy (q_push_rdy),
		.pop      (q_pop),
		.pop_rdy  (q_pop_rdy)
	);

	fpba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (q_pop),
		.op_rdy    (q_pop_rdy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	a_unknown_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.cmd != fpba_pkg::CMD_LOAD
		&& item.cmd != fpba_pkg::CMD_REQ && item.cmd != fpba_pkg::CMD_CLEAR)
		|-> !q_push.vld)
		else $error("unknown command entered the queue");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid
		&& $stable({result.granted, result.granted_size, result.wastage})))
		else $error("result word changed while waiting");

	a_waste_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.granted) |-> (result.wastage <= result.granted_size))
		else $error("wastage exceeds granted size");

	a_refusal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.granted)
		|-> (result.granted_size == '0 && result.wastage == '0))
		else $error("refused request carries a size");

endmodule

// File: hdl/fpba_front.sv
// ----------------------------------------------------------------------------
// fpba_front: command decode
// Accepts item words, maps commands onto queued operations, drops unknown codes.
// ----------------------------------------------------------------------------
module fpba_front (
	fpba_item_if.sink          item,
	output fpba_pkg::op_word_t push,
	input  logic               push_rdy
);

	fpba_pkg::op_kind_t kind;
	logic               known;

	always_comb begin
		kind  = fpba_pkg::OP_LOAD;
		known = 1'b1;
		case (item.cmd)
			fpba_pkg::CMD_LOAD:  kind = fpba_pkg::OP_LOAD;
			fpba_pkg::CMD_REQ:   kind = fpba_pkg::OP_REQ;
			fpba_pkg::CMD_CLEAR: kind = fpba_pkg::OP_CLEAR;
			default:             known = 1'b0;
		endcase
	end

	// take every word the queue has room for; unknown commands vanish here
	assign item.ready   = push_rdy;
	assign push.vld     = item.valid && push_rdy && known;
	assign push.op.kind = kind;
	assign push.op.size = (item.cmd == fpba_pkg::CMD_LOAD) ? item.block_size
		: item.request_size;
	assign push.op.last = item.last_request && (item.cmd == fpba_pkg::CMD_REQ);

endmodule

// File: hdl/fpba_queue.sv
// ----------------------------------------------------------------------------
// fpba_queue: operation queue
// Short FIFO between decode and execution so each side stalls on its own.
// ----------------------------------------------------------------------------
module fpba_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  fpba_pkg::op_word_t push,
	output logic               push_rdy,
	output fpba_pkg::op_word_t pop,
	input  logic               pop_rdy
);

	fpba_pkg::op_t                   mem_q [fpba_pkg::QDEPTH];
	logic [fpba_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [fpba_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [fpba_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_rdy = (cnt_q != fpba_pkg::QCNT_W'(fpba_pkg::QDEPTH));
	assign pop.vld  = (cnt_q != '0);
	assign pop.op   = mem_q[rd_ptr_q];
	assign do_push  = push.vld && push_rdy;
	assign do_pop   = pop.vld && pop_rdy;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/fpba_back.sv
// ----------------------------------------------------------------------------
// fpba_back: table and fit search
// Holds the block table and used marks, scans one entry a cycle per request.
// ----------------------------------------------------------------------------
module fpba_back (
	input  logic               clk,
	input  logic               arst_n,
	input  fpba_pkg::op_word_t op,
	output logic               op_rdy,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	fpba_result_if.source      result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	localparam int SW = fpba_pkg::SIZE_W;
	localparam int IW = fpba_pkg::IDX_W;
	localparam int CW = fpba_pkg::CNT_W;

	logic [SW-1:0]              tbl_mem [fpba_pkg::MAX_BLOCKS];
	logic [fpba_pkg::MAX_BLOCKS-1:0] used_q;

	state_t         state_q;
	logic [1:0]     policy_q;
	logic [CW-1:0]  cnt_q;
	logic [IW-1:0]  addr_q;
	logic           iss_q;
	logic           vld_s1;
	logic           last_s1;
	logic [IW-1:0]  idx_s1;
	logic [SW-1:0]  data_s1;
	logic [SW-1:0]  req_q;
	logic           req_last_q;
	logic           found_q;
	logic [IW-1:0]  pick_q;
	logic [SW-1:0]  pick_size_q;
	logic           res_vld_q;
	logic           granted_q;
	logic [SW-1:0]  gsize_q;
	logic [SW-1:0]  waste_q;

	logic           pop;
	logic           room;
	logic           load_wr;
	logic           addr_last;
	logic           elig;
	logic           take;
	logic           res_load;

	assign op_rdy    = (state_q == ST_IDLE);
	assign pop       = op.vld && op_rdy;
	assign room      = (cnt_q < CW'(fpba_pkg::MAX_BLOCKS));
	assign load_wr   = pop && (op.op.kind == fpba_pkg::OP_LOAD) && room;
	assign addr_last = ({1'b0, addr_q} == (cnt_q - 1'b1));
	assign res_load  = (state_q == ST_DONE) && (!res_vld_q || result.ready);

	assign result.valid        = res_vld_q;
	assign result.granted      = granted_q;
	assign result.granted_size = gsize_q;
	assign result.wastage      = waste_q;

	// candidate check on the entry read last cycle; ties keep the earlier one
	always_comb begin
		elig = vld_s1 && !used_q[idx_s1] && (data_s1 >= req_q);
		take = 1'b0;
		if (elig) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (policy_q)
					fpba_pkg::POL_BEST:  take = (data_s1 < pick_size_q);
					fpba_pkg::POL_WORST: take = (data_s1 > pick_size_q);
					default:             take = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_wr) begin
			tbl_mem[cnt_q[IW-1:0]] <= op.op.size;
		end
		data_s1 <= tbl_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= fpba_pkg::POL_FIRST;
			cnt_q       <= '0;
			used_q      <= '0;
			addr_q      <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			idx_s1      <= '0;
			req_q       <= '0;
			req_last_q  <= 1'b0;
			found_q     <= 1'b0;
			pick_q      <= '0;
			pick_size_q <= '0;
			res_vld_q   <= 1'b0;
			granted_q   <= 1'b0;
			gsize_q     <= '0;
			waste_q     <= '0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (res_vld_q && result.ready) begin
				res_vld_q <= 1'b0;
			end
			vld_s1  <= iss_q && (state_q == ST_SCAN);
			last_s1 <= addr_last;
			idx_s1  <= addr_q;
			if (take) begin
				found_q     <= 1'b1;
				pick_q      <= idx_s1;
				pick_size_q <= data_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (op.op.kind)
							fpba_pkg::OP_LOAD: begin
								if (room) begin
									used_q[cnt_q[IW-1:0]] <= 1'b0;
									cnt_q                 <= cnt_q + 1'b1;
								end
							end
							fpba_pkg::OP_REQ: begin
								req_q      <= op.op.size;
								req_last_q <= op.op.last;
								found_q    <= 1'b0;
								addr_q     <= '0;
								if (cnt_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									iss_q   <= 1'b1;
									state_q <= ST_SCAN;
								end
							end
							fpba_pkg::OP_CLEAR: begin
								cnt_q  <= '0;
								used_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					// issue one read a cycle, stop after the last loaded entry
					if (iss_q) begin
						if (addr_last) begin
							iss_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (vld_s1 && last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (res_load) begin
						granted_q <= found_q;
						gsize_q   <= found_q ? pick_size_q : '0;
						waste_q   <= found_q ? (pick_size_q - req_q) : '0;
						if (req_last_q) begin
							used_q <= '0;
						end else if (found_q) begin
							used_q[pick_q] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
